// ===== rtl/vrrs_pkg.sv =====
`timescale 1ns / 1ps

package vrrs_pkg;

   localparam int T_W    = 27;   // timer and on-time width
   localparam int MS_W   = 43;   // minutes times ms-per-minute, full precision
   localparam int ALU_W  = 45;   // three times that product
   localparam int CSR_W  = 11;   // widest configuration register

   localparam logic [15:0]    MS_PER_MIN     = 16'd60000;
   localparam logic [T_W-1:0] RESET_CYCLE_MS = 27'd900000;  // fifteen minutes

   typedef enum logic [2:0] {
      ACT_TICK      = 3'd0,
      ACT_SET_ON    = 3'd1,
      ACT_SET_EN    = 3'd2,
      ACT_SET_CYCLE = 3'd3,
      ACT_SET_SYS   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_ZERO   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ORDER_INTERLEAVED = 2'd0,
      ORDER_FORWARD     = 2'd1,
      ORDER_REVERSED    = 2'd2
   } order_type;

   typedef enum logic [1:0] {
      CSR_FLOORS   = 2'd0,
      CSR_VALVES   = 2'd1,
      CSR_ORDER    = 2'd2,
      CSR_INIT_MIN = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK,
      ST_MAP,
      ST_READ,
      ST_EVAL,
      ST_RESTART,
      ST_SUM,
      ST_TRIPLE,
      ST_CMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]     action;
      logic [5:0]     valve;
      logic [T_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic       open_flag;
      logic [5:0] open_valve;
      logic [6:0] position;
      logic       cycle_restarted;
      logic [1:0] status;
   } rsp_type;

endpackage

// ===== rtl/vrrs_ram.sv =====
`timescale 1ns / 1ps

module vrrs_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/valve_round_robin_sequencer.sv =====
`timescale 1ns / 1ps

// Irrigation valve sequencer. Each req_ transaction carries one action: a
// millisecond tick, an on-time write, a valve enable write, a cycle-time write
// or the system enable. Every request yields exactly one rsp_ transaction with
// the open valve, the sequence position, a restart flag and a status code.
// The csr_ port sets floors, valves per region, the order mode and the
// initial cycle length; csr_ready is always high and writes are meant for
// idle periods only.
// One request is processed at a time: req_ready is high only when idle.
// The shared add/subtract unit sets the pace. A tick runs two
// position-to-valve mappings while the system is on and the position is in
// range, else one; in interleaved order each mapping runs one subtraction
// per group of 2v positions before the position (v valves per region). A
// nonzero cycle-time write sums the on-times of all valves in use through
// the same unit, then runs one mapping. Other actions take one mapping.
// Reset restores all tables to their default on-time and enabled state
// through per-entry valid bits, so no clearing pass is needed.
// The result is held in an output register until rsp_ready; the next request
// is taken the cycle after it leaves.
module valve_round_robin_sequencer
   import vrrs_pkg::*;
#(
   parameter int MAX_FLOORS    = 4,
   parameter int MAX_VALVES    = 8,
   parameter int DEFAULT_ON_MS = 60000
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int TABLE_SIZE = MAX_FLOORS * 2 * MAX_VALVES;
   localparam int AW = $clog2(TABLE_SIZE);
   localparam int PW = $clog2(TABLE_SIZE + 1);
   localparam int FW = $clog2(MAX_FLOORS + 1);
   localparam int VW = $clog2(MAX_VALVES + 1);

   state_type state_ff, state_in;

   logic [2:0]       floors_ff, floors_in;
   logic [3:0]       vpr_ff, vpr_in;
   logic [1:0]       mode_ff, mode_in;
   logic             sys_on_ff, sys_on_in;
   logic [T_W-1:0]   cyc_len_ff, cyc_len_in;
   logic [T_W-1:0]   cyc_el_ff, cyc_el_in;
   logic [T_W-1:0]   vlv_el_ff, vlv_el_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic             open_ff, open_in;
   logic             restart_ff, restart_in;
   logic [1:0]       status_ff, status_in;
   logic [PW-1:0]    rem_ff, rem_in;
   logic [PW-1:0]    flat_ff, flat_in;
   logic             phase_out_ff, phase_out_in;
   logic [MS_W-1:0]  ms_ff, ms_in;
   logic [ALU_W-1:0] ms3_ff, ms3_in;
   logic [ALU_W-1:0] acc_ff, acc_in;
   logic [PW-1:0]    issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_idx_ff, pend_idx_in;
   logic [TABLE_SIZE-1:0] ot_vld_ff, ot_vld_in;
   logic [TABLE_SIZE-1:0] en_vld_ff, en_vld_in;
   rsp_type          rsp_ff, rsp_in;

   // clamped geometry
   logic [FW-1:0] used_floors;
   logic [VW-1:0] used_valves;
   logic [PW-1:0] total;
   logic [PW-1:0] v_ext;
   logic [PW-1:0] two_v;

   // shared add/subtract unit
   logic [ALU_W-1:0] alu_a, alu_b, alu_res;
   logic             alu_sub, alu_borrow;
   logic [ALU_W:0]   alu_full;

   // table memories
   logic           ot_we, en_we;
   logic [AW-1:0]  ot_waddr, en_waddr, rd_addr;
   logic [T_W-1:0] ot_wdata, ot_q;
   logic           en_wdata, en_q;
   logic [AW-1:0]  look_idx;
   logic [T_W-1:0] ot_eff;
   logic           en_eff;

   logic          accept, vidx_ok, map_done, issue_left;
   logic [PW-1:0] flat_calc;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      if (floors_ff == 3'd0) begin
         used_floors = FW'(1);
      end else if (int'(floors_ff) > MAX_FLOORS) begin
         used_floors = FW'(MAX_FLOORS);
      end else begin
         used_floors = FW'(floors_ff);
      end
      if (vpr_ff == 4'd0) begin
         used_valves = VW'(1);
      end else if (int'(vpr_ff) > MAX_VALVES) begin
         used_valves = VW'(MAX_VALVES);
      end else begin
         used_valves = VW'(vpr_ff);
      end
   end

   assign v_ext = PW'(used_valves);
   assign two_v = v_ext << 1;
   assign total = (PW'(used_floors) * v_ext) << 1;

   assign alu_full   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                               : ({1'b0, alu_a} + {1'b0, alu_b});
   assign alu_res    = alu_full[ALU_W-1:0];
   assign alu_borrow = alu_full[ALU_W];

   vrrs_ram #(.WIDTH(T_W), .DEPTH(TABLE_SIZE)) u_on_time_ram (
      .clock (clock),
      .we    (ot_we),
      .waddr (ot_waddr),
      .wdata (ot_wdata),
      .raddr (rd_addr),
      .rdata (ot_q)
   );

   vrrs_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_enable_ram (
      .clock (clock),
      .we    (en_we),
      .waddr (en_waddr),
      .wdata (en_wdata),
      .raddr (rd_addr),
      .rdata (en_q)
   );

   // entries never written read as their reset value
   assign look_idx = (state_ff == ST_SUM) ? pend_idx_ff : AW'(flat_ff);
   assign ot_eff   = ot_vld_ff[look_idx] ? ot_q : T_W'(DEFAULT_ON_MS);
   assign en_eff   = en_vld_ff[look_idx] ? en_q : 1'b1;

   assign vidx_ok    = int'(req_data.valve) < TABLE_SIZE;
   assign issue_left = issue_ff < total;

   // position to flat valve index; interleaved order uses rem = pos mod 2v
   always_comb begin
      case (mode_ff)
         ORDER_FORWARD:  flat_calc = pos_ff;
         ORDER_REVERSED: flat_calc = total - pos_ff - PW'(1);
         default:        flat_calc = pos_ff - rem_ff + (rem_ff[0] ? v_ext : '0)
                                     + (rem_ff >> 1);
      endcase
   end

   assign map_done = (mode_ff == ORDER_FORWARD) || (mode_ff == ORDER_REVERSED)
                     || alu_borrow;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_TICK) begin
                  state_in = ST_TICK;
               end else if (req_data.action == ACT_SET_CYCLE
                            && req_data.value != '0) begin
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_MAP;
               end
            end
         end
         ST_TICK: begin
            if (sys_on_ff && pos_ff < total) begin
               state_in = ST_MAP;
            end else begin
               state_in = ST_RESTART;
            end
         end
         ST_MAP: begin
            if (map_done) begin
               state_in = phase_out_ff ? ST_OUT : ST_READ;
            end
         end
         ST_READ:    state_in = ST_EVAL;
         ST_EVAL:    state_in = ST_RESTART;
         ST_RESTART: state_in = ST_MAP;
         ST_SUM: begin
            if (!issue_left && !pend_ff) begin
               state_in = ST_TRIPLE;
            end
         end
         ST_TRIPLE:  state_in = ST_CMP;
         ST_CMP:     state_in = ST_MAP;
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      floors_in    = floors_ff;
      vpr_in       = vpr_ff;
      mode_in      = mode_ff;
      sys_on_in    = sys_on_ff;
      cyc_len_in   = cyc_len_ff;
      cyc_el_in    = cyc_el_ff;
      vlv_el_in    = vlv_el_ff;
      pos_in       = pos_ff;
      open_in      = open_ff;
      restart_in   = restart_ff;
      status_in    = status_ff;
      flat_in      = flat_ff;
      phase_out_in = phase_out_ff;
      ms_in        = ms_ff;
      ms3_in       = ms3_ff;
      acc_in       = acc_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_in       = rsp_ff;
      ot_we        = 1'b0;
      ot_waddr     = AW'(req_data.valve);
      ot_wdata     = req_data.value;
      en_we        = 1'b0;
      en_waddr     = AW'(req_data.valve);
      en_wdata     = 1'b0;
      rd_addr      = AW'(flat_ff);
      alu_a        = '0;
      alu_b        = '0;
      alu_sub      = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in    = STAT_OK;
               restart_in   = 1'b0;
               phase_out_in = 1'b1;
               case (req_data.action)
                  ACT_SET_ON: begin
                     if (vidx_ok) begin
                        if (req_data.value == '0) begin
                           en_we     = 1'b1;
                           en_wdata  = 1'b0;
                           status_in = STAT_ZERO;
                        end else begin
                           ot_we = 1'b1;
                        end
                     end
                  end
                  ACT_SET_EN: begin
                     en_we    = vidx_ok;
                     en_wdata = req_data.value[0];
                  end
                  ACT_SET_CYCLE: begin
                     if (req_data.value == '0) begin
                        sys_on_in = 1'b0;
                        status_in = STAT_ZERO;
                     end else begin
                        ms_in    = MS_W'(req_data.value) * MS_W'(MS_PER_MIN);
                        acc_in   = '0;
                        issue_in = '0;
                        pend_in  = 1'b0;
                     end
                  end
                  ACT_SET_SYS: sys_on_in = req_data.value[0];
                  default: ;
               endcase
            end
         end
         ST_TICK: begin
            cyc_el_in = (cyc_el_ff == '1) ? cyc_el_ff : cyc_el_ff + T_W'(1);
            vlv_el_in = (vlv_el_ff == '1) ? vlv_el_ff : vlv_el_ff + T_W'(1);
            if (sys_on_ff && pos_ff < total) begin
               phase_out_in = 1'b0;
            end else if (!sys_on_ff) begin
               open_in = 1'b0;
            end
         end
         ST_MAP: begin
            alu_a = ALU_W'(rem_ff);
            alu_b = ALU_W'(two_v);
            if (map_done) begin
               flat_in = flat_calc;
               if (phase_out_ff) begin
                  rsp_in.open_flag       = open_ff;
                  rsp_in.open_valve      = (open_ff && pos_ff < total) ? 6'(flat_calc)
                                                                       : '0;
                  rsp_in.position        = 7'(pos_ff);
                  rsp_in.cycle_restarted = restart_ff;
                  rsp_in.status          = status_ff;
               end
            end
         end
         ST_EVAL: begin
            alu_a = ALU_W'(vlv_el_ff);
            alu_b = ALU_W'(ot_eff);
            if (en_eff) begin
               if (!open_ff) begin
                  open_in   = 1'b1;
                  vlv_el_in = '0;
               end else if (!alu_borrow) begin
                  open_in = 1'b0;
                  pos_in  = pos_ff + PW'(1);
               end
            end else begin
               open_in = 1'b0;
               pos_in  = pos_ff + PW'(1);
            end
         end
         ST_RESTART: begin
            alu_a        = ALU_W'(cyc_el_ff);
            alu_b        = ALU_W'(cyc_len_ff);
            phase_out_in = 1'b1;
            if (pos_ff >= total && !alu_borrow) begin
               pos_in     = '0;
               cyc_el_in  = '0;
               restart_in = 1'b1;
            end
         end
         ST_SUM: begin
            // read one entry per cycle, accumulate the one read last cycle
            alu_a   = acc_ff;
            alu_b   = ALU_W'(ot_eff);
            alu_sub = 1'b0;
            if (issue_left) begin
               rd_addr     = AW'(issue_ff);
               issue_in    = issue_ff + PW'(1);
               pend_in     = 1'b1;
               pend_idx_in = AW'(issue_ff);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               acc_in = alu_res;
            end
         end
         ST_TRIPLE: begin
            alu_a   = ALU_W'(ms_ff);
            alu_b   = ALU_W'({ms_ff, 1'b0});
            alu_sub = 1'b0;
            ms3_in  = alu_res;
         end
         ST_CMP: begin
            // sum below three quarters of the new length
            alu_a        = acc_ff;
            alu_b        = ALU_W'(ms3_ff[ALU_W-1:2]);
            phase_out_in = 1'b1;
            if (alu_borrow) begin
               cyc_len_in = (ms_ff[MS_W-1:T_W] != '0) ? '1 : ms_ff[T_W-1:0];
            end else begin
               status_in = STAT_REJECT;
            end
         end
         default: ;
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FLOORS: floors_in = csr_data[2:0];
            CSR_VALVES: vpr_in    = csr_data[3:0];
            CSR_ORDER:  mode_in   = csr_data[1:0];
            CSR_INIT_MIN: begin
               cyc_len_in = T_W'(csr_data) * T_W'(MS_PER_MIN);
            end
            default: ;
         endcase
      end

      ot_vld_in = ot_vld_ff;
      if (ot_we) begin
         ot_vld_in[ot_waddr] = 1'b1;
      end
      en_vld_in = en_vld_ff;
      if (en_we) begin
         en_vld_in[en_waddr] = 1'b1;
      end
   end

   // remainder restarts from the next position outside the mapping loop
   always_comb begin
      if (state_ff == ST_MAP && !map_done) begin
         rem_in = PW'(alu_res);
      end else begin
         rem_in = pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         floors_ff    <= 3'd1;
         vpr_ff       <= 4'd8;
         mode_ff      <= ORDER_INTERLEAVED;
         sys_on_ff    <= 1'b0;
         cyc_len_ff   <= RESET_CYCLE_MS;
         cyc_el_ff    <= '0;
         vlv_el_ff    <= '0;
         pos_ff       <= '0;
         open_ff      <= 1'b0;
         restart_ff   <= 1'b0;
         status_ff    <= STAT_OK;
         rem_ff       <= '0;
         phase_out_ff <= 1'b1;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         ot_vld_ff    <= '0;
         en_vld_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         floors_ff    <= floors_in;
         vpr_ff       <= vpr_in;
         mode_ff      <= mode_in;
         sys_on_ff    <= sys_on_in;
         cyc_len_ff   <= cyc_len_in;
         cyc_el_ff    <= cyc_el_in;
         vlv_el_ff    <= vlv_el_in;
         pos_ff       <= pos_in;
         open_ff      <= open_in;
         restart_ff   <= restart_in;
         status_ff    <= status_in;
         rem_ff       <= rem_in;
         phase_out_ff <= phase_out_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         ot_vld_ff    <= ot_vld_in;
         en_vld_ff    <= en_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      flat_ff     <= flat_in;
      ms_ff       <= ms_in;
      ms3_ff      <= ms3_in;
      acc_ff      <= acc_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction was in progress");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("not ready after result transaction");

   a_restart_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cycle_restarted |-> rsp_data.position == '0)
      else $error("restart without position reset");

   a_restart_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cycle_restarted |-> rsp_data.status == STAT_OK)
      else $error("restart flagged on a write action");

   a_closed_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.open_flag |-> rsp_data.open_valve == '0)
      else $error("open valve index reported while closed");
`endif

endmodule

// ===== tb/sv/valve_round_robin_sequencer_tb.sv =====
`timescale 1ns / 1ps

module valve_round_robin_sequencer_tb;
   import vrrs_pkg::*;

   localparam int NUM_VALVES    = 64;
   localparam int RAND_ITEMS    = 120;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int TAIL_CYCLES   = 200;
   localparam int HOLD_PHASE    = 2;
   localparam int PAUSE_PHASE   = 4;
   localparam int QUIET_PHASE   = 6;
   localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

   typedef struct packed {
      req_type item;
      logic    fixed;
      rsp_type want;
   } dir_row_t;

   typedef struct packed {
      logic [2:0]  floors;
      logic [3:0]  valves;
      logic [1:0]  order;
      logic [10:0] minutes;
   } phase_t;

   localparam rsp_type CLOSED_OK  = '{1'b0, 6'd0, 7'd0, 1'b0, STAT_OK};
   localparam rsp_type FIRST_OPEN = '{1'b1, 6'd0, 7'd0, 1'b0, STAT_OK};
   localparam rsp_type FIRST_ZERO = '{1'b1, 6'd0, 7'd0, 1'b0, STAT_ZERO};

   localparam int NUM_DIR = 24;
   localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
      // quiet after reset, then switch on and open the first valve
      '{'{ACT_TICK,      6'd0,  27'd0},          1'b1, CLOSED_OK},
      '{'{ACT_SET_SYS,   6'd0,  27'd1},          1'b1, CLOSED_OK},
      '{'{ACT_TICK,      6'd0,  27'd0},          1'b1, FIRST_OPEN},
      // zero on-time disables the open valve
      '{'{ACT_SET_ON,    6'd0,  27'd0},          1'b1, FIRST_ZERO},
      '{'{ACT_TICK,      6'd0,  27'd0},          1'b0, '0},
      '{'{ACT_TICK,      6'd63, 27'h7ffffff},    1'b0, '0},
      '{'{ACT_SET_ON,    6'd8,  27'd1},          1'b0, '0},
      '{'{ACT_TICK,      6'd0,  27'd0},          1'b0, '0},
      // valve outside the ones in use still gets its entry written
      '{'{ACT_SET_ON,    6'd63, 27'h7ffffff},    1'b0, '0},
      '{'{ACT_SET_EN,    6'd2,  27'h7fffffe},    1'b0, '0},
      '{'{ACT_SET_EN,    6'd63, 27'd1},          1'b0, '0},
      // zero cycle time turns the system off
      '{'{ACT_SET_CYCLE, 6'd0,  27'd0},          1'b0, '0},
      '{'{ACT_SET_CYCLE, 6'd0,  27'd1},          1'b0, '0},
      '{'{ACT_SET_CYCLE, 6'd0,  27'h7ffffff},    1'b0, '0},
      '{'{ACT_SET_SYS,   6'd0,  27'h7ffffff},    1'b0, '0},
      '{'{ACT_TICK,      6'd0,  27'd0},          1'b0, '0},
      // system off with a valve open: closes on the next tick
      '{'{ACT_SET_SYS,   6'd0,  27'd2},          1'b0, '0},
      '{'{ACT_TICK,      6'd0,  27'd0},          1'b0, '0},
      '{'{3'd5,          6'h2a, 27'h5555555},    1'b0, '0},
      '{'{3'd7,          6'h15, 27'h2aaaaaa},    1'b0, '0},
      '{'{ACT_SET_ON,    6'd5,  27'd86400000},   1'b0, '0},
      '{'{ACT_SET_CYCLE, 6'd0,  27'd20},         1'b0, '0},
      '{'{ACT_SET_EN,    6'd0,  27'd1},          1'b0, '0},
      '{'{3'd6,          6'd63, 27'd0},          1'b0, '0}
   };

   // last row is replaced by random settings at run time
   localparam int NUM_PHASES = 9;
   localparam phase_t PHASES [NUM_PHASES] = '{
      '{3'd4, 4'd8,  2'd2, 11'd0},
      '{3'd1, 4'd1,  2'd1, 11'd0},
      '{3'd0, 4'd0,  2'd3, 11'd0},
      '{3'd7, 4'd15, 2'd0, 11'd0},
      '{3'd2, 4'd3,  2'd0, 11'd0},
      '{3'd3, 4'd5,  2'd2, 11'd0},
      '{3'd4, 4'd8,  2'd0, 11'd0},
      '{3'd1, 4'd8,  2'd1, 11'd2047},
      '{3'd1, 4'd1,  2'd0, 11'd0}
   };

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_data  = '0;

   valve_round_robin_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // sequencer model state
   logic           sys_on;
   logic [T_W-1:0] cycle_len_ms;
   logic [T_W-1:0] cycle_ms;
   logic [T_W-1:0] valve_ms;
   logic [6:0]     seq_pos;
   logic           valve_open;
   logic [T_W-1:0] on_ms [NUM_VALVES];
   logic           valve_en [NUM_VALVES];
   logic [2:0]     cfg_floors;
   logic [3:0]     cfg_valves;
   logic [1:0]     cfg_order;
   logic [10:0]    cfg_minutes;

   rsp_type pending_status [$];
   int      err_count  = 0;
   logic    quiet      = 1'b0;
   int      hold_asked = 0;
   int      hold_done  = 0;
   int      hold_left  = 0;

   function automatic logic [T_W-1:0] minutes_ms(input logic [10:0] m);
      logic [MS_W-1:0] p;
      p = MS_W'(m) * MS_W'(MS_PER_MIN);
      return (p > MS_W'(T_MAX)) ? T_MAX : p[T_W-1:0];
   endfunction

   function automatic logic [T_W-1:0] sat_inc(input logic [T_W-1:0] x);
      return (x == T_MAX) ? x : x + 1'b1;
   endfunction

   function automatic int unsigned floors_used();
      if (cfg_floors < 1) return 1;
      if (cfg_floors > 4) return 4;
      return cfg_floors;
   endfunction

   function automatic int unsigned valves_used();
      if (cfg_valves < 1) return 1;
      if (cfg_valves > 8) return 8;
      return cfg_valves;
   endfunction

   function automatic int unsigned valves_total();
      return floors_used() * 2 * valves_used();
   endfunction

   function automatic int unsigned flat_valve(input int unsigned p);
      int unsigned v;
      int unsigned s;
      v = valves_used();
      if (cfg_order == ORDER_FORWARD) return p;
      if (cfg_order == ORDER_REVERSED) return valves_total() - 1 - p;
      s = p % (2 * v);
      return (p / (2 * v)) * 2 * v + (s % 2) * v + s / 2;
   endfunction

   function automatic void reset_sequencer();
      cfg_floors   = 3'd1;
      cfg_valves   = 4'd8;
      cfg_order    = ORDER_INTERLEAVED;
      cfg_minutes  = 11'd15;
      sys_on       = 1'b0;
      cycle_len_ms = minutes_ms(cfg_minutes);
      cycle_ms     = '0;
      valve_ms     = '0;
      seq_pos      = '0;
      valve_open   = 1'b0;
      for (int i = 0; i < NUM_VALVES; i++) begin
         on_ms[i]    = T_W'(60000);
         valve_en[i] = 1'b1;
      end
   endfunction

   function automatic void apply_csr(input logic [1:0] idx, input logic [CSR_W-1:0] d);
      case (idx)
         CSR_FLOORS: cfg_floors = d[2:0];
         CSR_VALVES: cfg_valves = d[3:0];
         CSR_ORDER:  cfg_order  = d[1:0];
         default: begin
            cfg_minutes  = d;
            cycle_len_ms = minutes_ms(d);
         end
      endcase
   endfunction

   function automatic rsp_type sequence_step(input req_type item);
      rsp_type     o;
      int unsigned total;
      int unsigned f;
      logic [63:0] ms;
      logic [63:0] sum;
      total = valves_total();
      o = '0;
      o.status = STAT_OK;
      case (item.action)
         ACT_TICK: begin
            cycle_ms = sat_inc(cycle_ms);
            valve_ms = sat_inc(valve_ms);
            if (sys_on) begin
               if (seq_pos < total) begin
                  f = flat_valve(seq_pos) % NUM_VALVES;
                  if (valve_en[f]) begin
                     if (!valve_open) begin
                        valve_open = 1'b1;
                        valve_ms   = '0;
                     end else if (valve_ms >= on_ms[f]) begin
                        valve_open = 1'b0;
                        seq_pos    = seq_pos + 1'b1;
                     end
                  end else begin
                     valve_open = 1'b0;
                     seq_pos    = seq_pos + 1'b1;
                  end
               end
            end else begin
               valve_open = 1'b0;
            end
            // restart check runs even while the system is off
            if (seq_pos >= total && cycle_ms >= cycle_len_ms) begin
               seq_pos  = '0;
               cycle_ms = '0;
               o.cycle_restarted = 1'b1;
            end
         end
         ACT_SET_ON: begin
            if (item.value == '0) begin
               valve_en[item.valve] = 1'b0;
               o.status = STAT_ZERO;
            end else begin
               on_ms[item.valve] = item.value;
            end
         end
         ACT_SET_EN: valve_en[item.valve] = item.value[0];
         ACT_SET_CYCLE: begin
            if (item.value == '0) begin
               sys_on   = 1'b0;
               o.status = STAT_ZERO;
            end else begin
               ms  = 64'(item.value) * 64'(MS_PER_MIN);
               sum = '0;
               for (int i = 0; i < total; i++) sum += 64'(on_ms[i]);
               if ((ms * 3) / 4 > sum)
                  cycle_len_ms = (ms > 64'(T_MAX)) ? T_MAX : ms[T_W-1:0];
               else
                  o.status = STAT_REJECT;
            end
         end
         ACT_SET_SYS: sys_on = item.value[0];
         default: ;
      endcase
      o.open_flag  = valve_open;
      o.open_valve = (valve_open && seq_pos < total) ? 6'(flat_valve(seq_pos)) : 6'd0;
      o.position   = seq_pos;
      return o;
   endfunction

   function automatic req_type random_action();
      req_type     r;
      int unsigned total;
      int unsigned pick;
      int unsigned sub;
      total = valves_total();
      pick = $urandom_range(999);
      sub  = $urandom_range(9);
      r.valve  = ($urandom_range(9) < 8) ? 6'($urandom_range(total - 1)) : 6'($urandom);
      r.value  = 27'($urandom);
      r.action = ACT_TICK;
      if (pick >= 740 && pick < 840) begin
         r.action = ACT_SET_ON;
         if (sub < 7) r.value = 27'($urandom_range(1, 3));
         else if (sub == 7) r.value = '0;
         else if (sub == 8) r.value = 27'($urandom_range(4, 20));
      end else if (pick >= 840 && pick < 900) begin
         r.action   = ACT_SET_EN;
         r.value[0] = (sub < 7);
      end else if (pick >= 900 && pick < 975) begin
         r.action   = ACT_SET_SYS;
         r.value[0] = (sub < 8);
      end else if (pick >= 975 && pick < 990) begin
         // an accepted cycle time stops restarts for the rest of the phase
         r.action = ACT_SET_CYCLE;
         if (sub < 7) r.value = '0;
         else if (sub < 9) r.value = 27'($urandom_range(1, 3));
      end else if (pick >= 990) begin
         r.action = 3'($urandom_range(5, 7));
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (err_count < 200)
         $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      err_count++;
   endtask

   task automatic check_status(input rsp_type got);
      rsp_type want;
      if (pending_status.size() == 0) begin
         report_mismatch("unexpected transaction", 8'(got), 8'd0);
         return;
      end
      want = pending_status.pop_front();
      if (got.open_flag !== want.open_flag)
         report_mismatch("open_flag", 8'(got.open_flag), 8'(want.open_flag));
      if (got.open_valve !== want.open_valve)
         report_mismatch("open_valve", 8'(got.open_valve), 8'(want.open_valve));
      if (got.position !== want.position)
         report_mismatch("position", 8'(got.position), 8'(want.position));
      if (got.cycle_restarted !== want.cycle_restarted)
         report_mismatch("cycle_restarted", 8'(got.cycle_restarted),
                         8'(want.cycle_restarted));
      if (got.status !== want.status)
         report_mismatch("status", 8'(got.status), 8'(want.status));
   endtask

   task automatic send_action(input req_type item, input logic use_fixed = 1'b0,
                              input rsp_type fixed_rsp = '0);
      rsp_type predicted;
      int      gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = sequence_step(item);
      pending_status.push_back(use_fixed ? fixed_rsp : predicted);
      gap = 0;
      while (!quiet && $urandom_range(99) < 7) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [CSR_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, d);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side: check, random stalls, and the long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) check_status(rsp_data);
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (hold_done != hold_asked) begin
         hold_done <= hold_done + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 7);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("valve_round_robin_sequencer_tb: errors");
      $finish;
   end

   initial begin
      phase_t  pc;
      req_type item;
      int      total;
      reset_sequencer();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIR; i++)
         send_action(DIR_ROWS[i].item, DIR_ROWS[i].fixed, DIR_ROWS[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         pc = PHASES[p];
         if (p == NUM_PHASES - 1) begin
            pc.floors  = 3'($urandom);
            pc.valves  = 4'($urandom);
            pc.order   = 2'($urandom);
            pc.minutes = 11'($urandom_range(1));
         end
         drain_all();
         write_csr(CSR_FLOORS, {8'($urandom), pc.floors});
         write_csr(CSR_VALVES, {7'($urandom), pc.valves});
         write_csr(CSR_ORDER, {9'($urandom), pc.order});
         write_csr(CSR_INIT_MIN, pc.minutes);
         csr_valid <= 1'b0;
         quiet     <= (p == QUIET_PHASE);

         // short on-times for every valve in use, then switch on
         total = valves_total();
         for (int v = 0; v < total; v++) begin
            if (!valve_en[v]) begin
               item = '{ACT_SET_EN, 6'(v), 27'($urandom) | 27'd1};
               send_action(item);
            end
            item = '{ACT_SET_ON, 6'(v), 27'($urandom_range(1, 3))};
            send_action(item);
         end
         item = '{ACT_SET_SYS, 6'($urandom), 27'($urandom) | 27'd1};
         send_action(item);

         if (p == HOLD_PHASE) hold_asked <= hold_asked + 1;
         for (int n = 0; n < RAND_ITEMS; n++) begin
            if (p == PAUSE_PHASE && n == RAND_ITEMS / 2) drain_all();
            send_action(random_action());
         end
         quiet <= 1'b0;
      end

      drain_all();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_status.size() == 0)
         $display("valve_round_robin_sequencer_tb: clean");
      else
         $display("valve_round_robin_sequencer_tb: errors");
      $finish;
   end

endmodule
